// ===== rtl/a64pcr_pkg.sv =====
// ----------------------------------------------------------------------------
// a64pcr_pkg: shared types for the ARM64 PC-relative target decode
// Operation codes and the offset record passed from decode to the adder.
// ----------------------------------------------------------------------------
`default_nettype none

package a64pcr_pkg;

    localparam int unsigned OFF_W  = 34;  // widest offset: 33-bit ADRP plus LDR imm
    localparam int unsigned ADDR_W = 64;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned PAGE_W = 12;

    typedef enum logic [1:0] {
        OP_B26  = 2'd0,
        OP_B19  = 2'd1,
        OP_B14  = 2'd2,
        OP_PAIR = 2'd3
    } t_op;

    typedef struct packed {
        logic                    page_align;  // clear low address bits (ADRP)
        logic signed [OFF_W-1:0] offset;      // byte offset, sign extended
    } t_offset;

endpackage

`default_nettype wire

// ===== rtl/a64pcr_decode.sv =====
// ----------------------------------------------------------------------------
// a64pcr_decode: immediate extraction for PC-relative instructions
// Pulls the branch, ADR or ADRP+ADD/LDR immediate out of the instruction
// words and forms one signed byte offset plus a page-align flag.
// ----------------------------------------------------------------------------
`default_nettype none

module a64pcr_decode
    import a64pcr_pkg::*;
(
    input  var t_op               i_op,
    input  wire logic [WORD_W-1:0] i_first_word,
    input  wire logic [WORD_W-1:0] i_second_word,
    output t_offset               o_offset
);

    logic [20:0] imm21;
    logic [11:0] imm12;
    logic [1:0]  ldr_size;
    logic        ldr_v;
    logic [1:0]  ldr_opc;
    logic [4:0]  ldr_class;
    logic [2:0]  ldr_shift;
    logic        is_ldr;
    logic [18:0] ldr_imm;
    logic [32:0] adrp_off;

    assign imm21     = {i_first_word[23:5], i_first_word[30:29]};
    assign imm12     = i_second_word[21:10];
    assign ldr_size  = i_second_word[31:30];
    assign ldr_v     = i_second_word[26];
    assign ldr_opc   = i_second_word[23:22];
    assign ldr_class = {ldr_size, ldr_v, ldr_opc};
    assign is_ldr    = i_second_word[27] & ~i_second_word[25];
    assign adrp_off  = {imm21, 12'h000};
    assign ldr_imm   = {7'd0, imm12} << ldr_shift;

    // Access size scale of the LDR immediate
    always_comb begin
        if (ldr_v) begin
            ldr_shift = {ldr_opc[1], ldr_size};
        end else begin
            case (ldr_class) inside
                5'd9, 5'd10, 5'd11: ldr_shift = 3'd1;
                5'd18:              ldr_shift = 3'd2;
                5'd17, 5'd25:       ldr_shift = {1'b0, ldr_size};
                default:            ldr_shift = 3'd0;
            endcase
        end
    end

    always_comb begin
        o_offset.page_align = 1'b0;
        case (i_op)
            OP_B26: begin
                o_offset.offset = {{6{i_first_word[25]}}, i_first_word[25:0], 2'b00};
            end
            OP_B19: begin
                o_offset.offset = {{13{i_first_word[23]}}, i_first_word[23:5], 2'b00};
            end
            OP_B14: begin
                o_offset.offset = {{18{i_first_word[18]}}, i_first_word[18:5], 2'b00};
            end
            OP_PAIR: begin
                if (is_ldr) begin
                    o_offset.page_align = 1'b1;
                    o_offset.offset = {adrp_off[32], adrp_off} + {15'd0, ldr_imm};
                end else if (i_first_word[31]) begin
                    o_offset.page_align = 1'b1;
                    o_offset.offset = {adrp_off[32], adrp_off} + {22'd0, imm12};
                end else begin
                    o_offset.offset = {{13{imm21[20]}}, imm21};
                end
            end
            default: begin
                o_offset.offset = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/arm64_branch_and_adrp_target_decode.sv =====
// ----------------------------------------------------------------------------
// arm64_branch_and_adrp_target_decode: ARM64 PC-relative target address
// Resolves B/BL, CBZ/B.cond, TBZ and ADR/ADRP+ADD/ADRP+LDR targets.
// ----------------------------------------------------------------------------
// Path: a request is captured in the input register, decoded and added
//   combinationally, then captured in the result register that drives
//   o_valid and o_target.
// Throughput: one request per cycle while the result side is not stalled;
//   the decode plus one 64-bit add between the two registers sets the cycle.
// Reset: synchronous, active low; clears both valid flags, payload untouched.
// ----------------------------------------------------------------------------
`default_nettype none

module arm64_branch_and_adrp_target_decode
    import a64pcr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_operation,
    input  wire logic [WORD_W-1:0] i_first_word,
    input  wire logic [WORD_W-1:0] i_second_word,
    input  wire logic [ADDR_W-1:0] i_instr_address,
    // result channel
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [ADDR_W-1:0]      o_target
);

    // Input stage
    logic              r_s1_valid;
    t_op               r_op;
    logic [WORD_W-1:0] r_w0;
    logic [WORD_W-1:0] r_w1;
    logic [ADDR_W-1:0] r_addr;

    // Result stage
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_target;
    logic [ADDR_W-1:0] n_target;

    logic    out_free;   // result register can take a new value
    logic    s1_adv;     // input stage hands its request on
    logic    in_take;
    t_offset off;
    logic [ADDR_W-1:0] base;

    // The result register decouples the sides: the input stage moves
    // whenever the result register is empty or being drained.
    assign out_free = ~r_out_valid | i_ready;
    assign s1_adv   = r_s1_valid & out_free;
    assign o_ready  = ~r_s1_valid | out_free;
    assign in_take  = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    // Capture request payload; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= t_op'(i_operation);
            r_w0   <= i_first_word;
            r_w1   <= i_second_word;
            r_addr <= i_instr_address;
        end
    end

    a64pcr_decode u_decode (
        .i_op          (r_op),
        .i_first_word  (r_w0),
        .i_second_word (r_w1),
        .o_offset      (off)
    );

    // ADRP forms use the 4 KiB page of the instruction; the rest use the
    // address itself. One wide add finishes the target.
    assign base     = off.page_align ? {r_addr[ADDR_W-1:PAGE_W], {PAGE_W{1'b0}}} : r_addr;
    assign n_target = base + {{(ADDR_W-OFF_W){off.offset[OFF_W-1]}}, off.offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_target <= n_target;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_target = r_target;

    // A full input stage that cannot advance keeps its request
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> r_s1_valid)
        else $error("input stage dropped a stalled request");

    // Back-pressure only when both stages are occupied
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_s1_valid && r_out_valid && !i_ready))
        else $error("ready deasserted with a free stage");

    // A new result appears only from a filled input stage
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_free && !r_s1_valid) |=> !r_out_valid)
        else $error("result produced without a request");

    // An accepted request always lands in the input stage
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_s1_valid)
        else $error("accepted request lost");

endmodule

`default_nettype wire

// ===== tb/sv/arm64_branch_and_adrp_target_decode_test.sv =====
// ----------------------------------------------------------------------------
// arm64_branch_and_adrp_target_decode_test: self-checking target decode bench
// Feeds branch, ADR and ADRP-pair requests through a valid/ready driver,
// computes each expected target with a local decoder, and compares every
// result in order with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module arm64_branch_and_adrp_target_decode_test;
    timeunit 1ns;
    timeprecision 1ps;

    import a64pcr_pkg::*;

    localparam int unsigned RANDOM_REQUESTS = 1500;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned IDLE_PERCENT    = 38;
    localparam int unsigned DRAIN_CYCLES    = 8;   // idle margin after the last result is back

    typedef struct {
        t_op         op;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic [63:0] instr_address;
        bit          drain_first;  // hold until every expected target is back
    } t_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [31:0] i_first_word;
    logic [31:0] i_second_word;
    logic [63:0] i_instr_address;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_target;

    t_request    pending_requests[$];
    logic [63:0] expected_targets[$];
    int unsigned accepted_count;
    int unsigned cycle_count;
    int unsigned error_count;
    bit          request_taken;   // request accepted at the last rising edge
    logic        steady_phase;

    arm64_branch_and_adrp_target_decode DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_first_word    (i_first_word),
        .i_second_word   (i_second_word),
        .i_instr_address (i_instr_address),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_target        (o_target)
    );

    // Drop idling on both sides for a long stretch in the middle of the run.
    assign steady_phase = (accepted_count >= 700) && (accepted_count < 1000);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Decoder: scale of the LDR unsigned offset from size, V and opc
    // ------------------------------------------------------------------------
    function automatic int unsigned ldr_scale(input logic [31:0] ldr_word);
        logic [1:0] size;
        logic       vec;
        logic [1:0] opc;
        logic [4:0] kind;
        size = ldr_word[31:30];
        vec  = ldr_word[26];
        opc  = ldr_word[23:22];
        kind = {size, vec, opc};
        if (vec)
            return {opc[1], size};
        case (kind)
            5'd9, 5'd10, 5'd11: return 1;
            5'd18:              return 2;
            5'd17, 5'd25:       return size;
            default:            return 0;
        endcase
    endfunction

    function automatic logic [63:0] predict_target(input t_request req);
        logic [20:0] imm21;
        logic [63:0] page_base;
        logic [63:0] imm12;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [63:0] pc;
        w0    = req.first_word;
        w1    = req.second_word;
        pc    = req.instr_address;
        imm21 = {w0[23:5], w0[30:29]};
        // ADRP page: 33-bit signed page offset added to the 4 KiB aligned pc
        page_base = {{31{imm21[20]}}, imm21, 12'b0} + {pc[63:12], 12'b0};
        imm12     = {52'b0, w1[21:10]};
        case (req.op)
            OP_B26:  return pc + {{36{w0[25]}}, w0[25:0], 2'b00};
            OP_B19:  return pc + {{43{w0[23]}}, w0[23:5], 2'b00};
            OP_B14:  return pc + {{48{w0[18]}}, w0[18:5], 2'b00};
            default: begin
                // Load class wins over the first word's ADR/ADRP bit.
                if (w1[27] && !w1[25])
                    return page_base + (imm12 << ldr_scale(w1));
                if (w0[31])
                    return page_base + imm12;
                return pc + {{43{imm21[20]}}, imm21};
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic add_request(input t_op op, input logic [31:0] w0,
                               input logic [31:0] w1, input logic [63:0] pc,
                               input bit drain);
        t_request req;
        req.op            = op;
        req.first_word    = w0;
        req.second_word   = w1;
        req.instr_address = pc;
        req.drain_first   = drain;
        pending_requests.push_back(req);
    endtask

    function automatic logic [63:0] random_address();
        case ($urandom_range(7))
            0:       return 64'hFFFF_FFFF_FFFF_F000 | 64'($urandom_range(4095));
            1:       return 64'($urandom_range(8191));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : run_sequence
        t_op         op;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [63:0] all_ones;

        all_ones        = '1;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_ready         = 1'b0;
        i_operation     = '0;
        i_first_word    = '0;
        i_second_word   = '0;
        i_instr_address = '0;

        // Directed: sign extremes of every branch immediate, wrap at both ends.
        add_request(OP_B26, 32'h0200_0000, 32'h0, 64'h0, 1'b0);
        add_request(OP_B26, 32'h01FF_FFFF, 32'hFFFF_FFFF, all_ones, 1'b0);
        add_request(OP_B26, 32'hFFFF_FFFF, 32'h0, 64'h1000, 1'b0);
        add_request(OP_B19, 32'h0080_0000, 32'h0, 64'h0, 1'b0);
        add_request(OP_B19, 32'h007F_FFE0, 32'h0, all_ones, 1'b0);
        add_request(OP_B19, 32'hFF00_001F, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 1'b0);
        add_request(OP_B14, 32'h0004_0000, 32'h0, 64'h0, 1'b0);
        add_request(OP_B14, 32'h0003_FFE0, 32'h0, all_ones, 1'b0);
        add_request(OP_B14, 32'hFFF8_001F, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        // ADR, both sign extremes of imm21
        add_request(OP_PAIR, 32'h707F_FFE0, 32'h0, all_ones, 1'b0);
        add_request(OP_PAIR, 32'h1080_0000, 32'h0, 64'h0, 1'b0);
        // ADRP+ADD, page extremes; the ADD shift bit is ignored
        add_request(OP_PAIR, 32'hF07F_FFE0, 32'h913F_FC00, all_ones, 1'b0);
        add_request(OP_PAIR, 32'h9080_0000, 32'h917F_FC00, 64'h0000_0000_0000_0FFF, 1'b0);
        // ADRP+LDR through every scale rule
        add_request(OP_PAIR, 32'h9000_0020, 32'hF97F_FC00, 64'h1234_5678_9ABC_DEF0, 1'b0);
        add_request(OP_PAIR, 32'h9000_0020, 32'hB97F_FC00, 64'h1234_5678_9ABC_DEF0, 1'b0);
        add_request(OP_PAIR, 32'h9000_0020, 32'h797F_FC00, 64'h1234_5678_9ABC_DEF0, 1'b0);
        add_request(OP_PAIR, 32'h9000_0020, 32'h79BF_FC00, all_ones, 1'b0);
        add_request(OP_PAIR, 32'h9000_0020, 32'h79FF_FC00, all_ones, 1'b0);
        add_request(OP_PAIR, 32'h9000_0020, 32'hB9BF_FC00, all_ones, 1'b0);
        add_request(OP_PAIR, 32'h9000_0020, 32'h3DFF_FC00, 64'h0, 1'b0);
        add_request(OP_PAIR, 32'h9000_0020, 32'hFDFF_FC00, all_ones, 1'b0);
        add_request(OP_PAIR, 32'h9000_0020, 32'h397F_FC00, 64'h0, 1'b0);
        // load class behind a first word that is not ADRP
        add_request(OP_PAIR, 32'h1000_0000, 32'hF97F_FC00, 64'hFFFF_FFFF_FFFF_F800, 1'b0);
        // bit 27 set with bit 25 set is not a load: ADD path, then ADR path
        add_request(OP_PAIR, 32'h9000_0000, 32'h0A3F_FC00, 64'h4000, 1'b0);
        add_request(OP_PAIR, 32'h1000_0000, 32'h0A3F_FC00, 64'h4000, 1'b0);

        // Random part; hold the sender until drained at the start and midway.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            op = t_op'($urandom_range(3));
            w0 = $urandom;
            w1 = $urandom;
            if (op == OP_PAIR) begin
                case ($urandom_range(3))
                    0: begin
                        w1[27] = 1'b1;
                        w1[25] = 1'b0;
                    end
                    1: begin
                        w0[31] = 1'b1;
                        if (w1[27])
                            w1[25] = 1'b1;
                    end
                    2: begin
                        w0[31] = 1'b0;
                        w1[27] = 1'b0;
                    end
                    default: ;
                endcase
            end
            add_request(op, w0, w1, random_address(), (n == 0) || (n == 600));
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;   // nonblocking: the driver sees reset for this edge

        while (pending_requests.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_targets.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: advance to the next request only after acceptance
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_requests
        t_request req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || request_taken) begin
            if (pending_requests.size() == 0) begin
                i_valid <= 1'b0;
            end else if (pending_requests[0].drain_first && expected_targets.size() != 0) begin
                i_valid <= 1'b0;   // hold until the pipe is empty
            end else if (!steady_phase && $urandom_range(99) < IDLE_PERCENT) begin
                i_valid <= 1'b0;
            end else begin
                req = pending_requests.pop_front();
                i_valid         <= 1'b1;
                i_operation     <= req.op;
                i_first_word    <= req.first_word;
                i_second_word   <= req.second_word;
                i_instr_address <= req.instr_address;
            end
        end
    end

    // Result side back-pressure
    always @(negedge i_clk) begin : drive_result_ready
        i_ready <= steady_phase || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Monitor: check results against the oldest expectation, then record
    // the expectation for any request accepted at this edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_targets
        t_request    req;
        logic [63:0] want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            request_taken = 1'b0;
            if (i_rst_n) begin
                if (o_valid && i_ready) begin
                    if (expected_targets.size() == 0) begin
                        report_mismatch($sformatf("unexpected result target=%h", o_target));
                    end else begin
                        want = expected_targets.pop_front();
                        if (o_target !== want)
                            report_mismatch($sformatf("target got %h want %h",
                                                      o_target, want));
                    end
                end
                if (i_valid && o_ready) begin
                    req.op            = t_op'(i_operation);
                    req.first_word    = i_first_word;
                    req.second_word   = i_second_word;
                    req.instr_address = i_instr_address;
                    req.drain_first   = 1'b0;
                    expected_targets.push_back(predict_target(req));
                    accepted_count++;
                    request_taken = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/a64pcr_pkg.sv
rtl/a64pcr_decode.sv
rtl/arm64_branch_and_adrp_target_decode.sv
tb/sv/arm64_branch_and_adrp_target_decode_test.sv
